FILE: rtl/tiff_directory_bounds_checker_assert.svh
// Assertion macros used by the checker's core RTL.
`ifndef TIFF_DIRECTORY_BOUNDS_CHECKER_ASSERT_SVH
`define TIFF_DIRECTORY_BOUNDS_CHECKER_ASSERT_SVH

`ifndef SYNTH

`define TDBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TDBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TDBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define TDBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/tdbc_pkg.sv
`default_nettype none

package tdbc_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int CMP_W       = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

    localparam int FILE_LEN_W  = 32;
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_IDX_W   = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_FILE_LEN = '0;

    localparam int FIELD_W   = 32;
    localparam int COUNT_W   = 16;
    localparam int VERDICT_W = 3;
    localparam int HDR_BYTES = 8;

    localparam logic [7:0] CHAR_I    = 8'h49;
    localparam logic [7:0] CHAR_M    = 8'h4D;
    localparam logic [7:0] MAGIC     = 8'd42;
    localparam logic [7:0] BYTE_ZERO = 8'd0;

    localparam int DIR_FIXED_BYTES = 6;
    localparam logic [3:0] ENTRY_LAST = 4'd11;
    localparam logic [35:0] INLINE_BYTES = 36'd4;

    localparam logic [15:0] TYPE_SHORT     = 16'd3;
    localparam logic [15:0] TYPE_LONG      = 16'd4;
    localparam logic [15:0] TYPE_RATIONAL  = 16'd5;
    localparam logic [15:0] TYPE_SRATIONAL = 16'd10;
    localparam logic [15:0] TYPE_LONG8     = 16'd16;
    localparam logic [15:0] TYPE_SLONG8    = 16'd17;

    localparam logic [3:0] SIZE_ONE   = 4'd1;
    localparam logic [3:0] SIZE_TWO   = 4'd2;
    localparam logic [3:0] SIZE_FOUR  = 4'd4;
    localparam logic [3:0] SIZE_EIGHT = 4'd8;

    localparam logic [VERDICT_W-1:0] VERDICT_OK        = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_NOT_TIFF  = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_NO_DIR    = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_TOO_SMALL = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_OFF_END   = 3'd4;
    localparam logic [VERDICT_W-1:0] VERDICT_DIR_TRUNC = 3'd5;
    localparam logic [VERDICT_W-1:0] VERDICT_DIR_END   = 3'd6;
    localparam logic [VERDICT_W-1:0] VERDICT_TAG_END   = 3'd7;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_COUNT  = 5'b00100,
        PH_ENTRY  = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    function automatic logic [FIELD_W-1:0] gather(
        input logic [FIELD_W-1:0] acc,
        input logic [7:0]         b,
        input logic [1:0]         k,
        input logic               le
    );
        logic [FIELD_W-1:0] wide;
        wide = {24'd0, b};
        if (k == 2'd0) begin
            return wide;
        end
        else if (le) begin
            return acc | (wide << {k, 3'b000});
        end
        else begin
            return {acc[FIELD_W-9:0], b};
        end
    endfunction

    function automatic logic [3:0] type_size(input logic [15:0] t);
        case (t) inside
            TYPE_SHORT:                                        return SIZE_TWO;
            TYPE_LONG:                                         return SIZE_FOUR;
            TYPE_RATIONAL, TYPE_SRATIONAL, TYPE_LONG8, TYPE_SLONG8: return SIZE_EIGHT;
            default:                                           return SIZE_ONE;
        endcase
    endfunction

    function automatic logic [35:0] scaled_len(
        input logic [FIELD_W-1:0] cnt,
        input logic [3:0]         sz
    );
        case (sz)
            SIZE_TWO:   return {3'b000, cnt, 1'b0};
            SIZE_FOUR:  return {2'b00, cnt, 2'b00};
            SIZE_EIGHT: return {1'b0, cnt, 3'b000};
            default:    return {4'b0000, cnt};
        endcase
    endfunction

    function automatic logic dir_too_long(
        input logic [FIELD_W-1:0]    off,
        input logic [COUNT_W-1:0]    cnt,
        input logic [FILE_LEN_W-1:0] flen
    );
        logic [33:0] dir_end;
        dir_end = 34'(off) + 34'(DIR_FIXED_BYTES) + (34'(cnt) << 3) + (34'(cnt) << 2);
        return dir_end > 34'(flen);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tdbc_in_if.sv
`default_nettype none

interface tdbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/tdbc_out_if.sv
`default_nettype none

interface tdbc_out_if;
    logic                           valid;
    logic                           ready;
    logic [tdbc_pkg::VERDICT_W-1:0] verdict;
    logic                           little_endian;
    logic [tdbc_pkg::COUNT_W-1:0]   bad_entry;

    modport source (output valid, output verdict, output little_endian, output bad_entry,
                    input ready);
    modport sink   (input valid, input verdict, input little_endian, input bad_entry,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/tdbc_apb_regs.sv
`default_nettype none

module tdbc_apb_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tdbc_pkg::PADDR_W-1:0]       paddr,
    input  logic [tdbc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tdbc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [tdbc_pkg::FILE_LEN_W-1:0]    file_len
);
    import tdbc_pkg::*;

    logic [FILE_LEN_W-1:0]  file_len_reg;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_FILE_LEN);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_len_reg <= '0;
        end
        else if (wr_en)
        begin
            file_len_reg <= pwdata[FILE_LEN_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FILE_LEN: prdata = APB_DATA_W'(file_len_reg);
            default:      prdata = '0;
        endcase
    end

    assign file_len = file_len_reg;

endmodule

`default_nettype wire

FILE: rtl/tdbc_core.sv
`default_nettype none
`include "tiff_directory_bounds_checker_assert.svh"

module tdbc_core (
    input  logic                            clk,
    input  logic                            rst_n,
    tdbc_in_if.sink                         item,
    tdbc_out_if.source                      result,
    input  logic [tdbc_pkg::FILE_LEN_W-1:0] file_len
);
    import tdbc_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       adv;

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [7:0]             hdr_reg [HDR_BYTES];
    logic                   le_reg, le_next;
    logic [FIELD_W-1:0]     dir_off_reg, dir_off_next;
    logic [COUNT_W-1:0]     total_reg, total_next;
    logic [COUNT_W-1:0]     en_reg, en_next;
    logic [3:0]             eb_reg, eb_next;
    logic [FIELD_W-1:0]     fs_reg, fs_next;
    logic [3:0]             ts_reg, ts_next;
    logic [FIELD_W-1:0]     vc_reg, vc_next;
    phase_t                 phase_reg, phase_next;

    logic                 fin;
    logic [VERDICT_W-1:0] fin_v;
    logic [COUNT_W-1:0]   fin_bad;
    logic                 res_le;

    logic                 out_valid_reg;
    logic [VERDICT_W-1:0] out_verdict_reg;
    logic                 out_le_reg;
    logic [COUNT_W-1:0]   out_bad_reg;

    logic [63:0]        hv;
    logic [63:0]        sh;
    logic               hdr_le;
    logic               hdr_be;
    logic [FIELD_W-1:0] ifd;
    logic [2:0]         ofs;
    logic [FIELD_W-1:0] cnt_fs;
    logic [FIELD_W-1:0] typ_fs;
    logic [1:0]         ent_k;
    logic [35:0]        tag_len;

    // pipeline handshake
    assign adv        = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_byte_reg <= item.data_byte;
            s1_last_reg <= item.is_last;
        end
    end

    // header decode on the eighth byte
    assign hv = {s1_byte_reg, hdr_reg[6], hdr_reg[5], hdr_reg[4],
                 hdr_reg[3], hdr_reg[2], hdr_reg[1], hdr_reg[0]};
    assign hdr_le = (hdr_reg[0] == CHAR_I) && (hdr_reg[1] == CHAR_I) &&
                    (hdr_reg[2] == MAGIC) && (hdr_reg[3] == BYTE_ZERO);
    assign hdr_be = (hdr_reg[0] == CHAR_M) && (hdr_reg[1] == CHAR_M) &&
                    (hdr_reg[2] == BYTE_ZERO) && (hdr_reg[3] == MAGIC);
    assign ifd = hdr_le ? {s1_byte_reg, hdr_reg[6], hdr_reg[5], hdr_reg[4]}
                        : {hdr_reg[4], hdr_reg[5], hdr_reg[6], s1_byte_reg};
    assign ofs = ifd[2:0];
    assign sh  = hv >> {ofs, 3'b000};
    assign cnt_fs = hdr_le ? {16'd0, sh[15:8], sh[7:0]} : {16'd0, sh[7:0], sh[15:8]};
    assign typ_fs = hdr_le ? {16'd0, sh[47:40], sh[39:32]} : {16'd0, sh[39:32], sh[47:40]};

    assign ent_k   = (eb_reg >= 4'd4) ? eb_reg[1:0] : 2'(eb_reg[1:0] - 2'd2);
    assign tag_len = scaled_len(vc_reg, ts_reg);

    always_comb
    begin
        pos_next     = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        le_next      = le_reg;
        dir_off_next = dir_off_reg;
        total_next   = total_reg;
        en_next      = en_reg;
        eb_next      = eb_reg;
        fs_next      = fs_reg;
        ts_next      = ts_reg;
        vc_next      = vc_reg;
        phase_next   = phase_reg;
        fin          = 1'b0;
        fin_v        = VERDICT_OK;
        fin_bad      = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg == OFFSET_BITS'(HDR_BYTES - 1))
                begin
                    if (!hdr_le && !hdr_be)
                    begin
                        fin   = 1'b1;
                        fin_v = VERDICT_NOT_TIFF;
                    end
                    else
                    begin
                        le_next      = hdr_le;
                        dir_off_next = ifd;
                        if (ifd == '0)
                        begin
                            fin   = 1'b1;
                            fin_v = VERDICT_NO_DIR;
                        end
                        else if (ifd >= file_len)
                        begin
                            fin   = 1'b1;
                            fin_v = VERDICT_OFF_END;
                        end
                        else if (ifd < FIELD_W'(HDR_BYTES))
                        begin
                            // replay the buffered tail of the header as directory bytes
                            if (ofs == 3'd7)
                            begin
                                phase_next = PH_COUNT;
                                eb_next    = 4'd1;
                                fs_next    = {24'd0, sh[7:0]};
                            end
                            else
                            begin
                                fs_next    = cnt_fs;
                                total_next = cnt_fs[COUNT_W-1:0];
                                if (dir_too_long(ifd, cnt_fs[COUNT_W-1:0], file_len))
                                begin
                                    fin   = 1'b1;
                                    fin_v = VERDICT_DIR_END;
                                end
                                else if (cnt_fs[COUNT_W-1:0] == '0)
                                begin
                                    fin = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_ENTRY;
                                    en_next    = '0;
                                    eb_next    = {1'b0, 3'(3'd6 - ofs)};
                                    case (ofs)
                                        3'd1:
                                        begin
                                            fs_next = {24'd0, sh[55:48]};
                                            ts_next = type_size(typ_fs[15:0]);
                                        end
                                        3'd2:
                                        begin
                                            fs_next = typ_fs;
                                            ts_next = type_size(typ_fs[15:0]);
                                        end
                                        3'd3:    fs_next = {24'd0, sh[39:32]};
                                        default: fs_next = cnt_fs;
                                    endcase
                                end
                            end
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                if (CMP_W'(pos_reg) == CMP_W'(dir_off_reg))
                begin
                    phase_next = PH_COUNT;
                    eb_next    = 4'd1;
                    fs_next    = {24'd0, s1_byte_reg};
                end
            end
            PH_COUNT:
            begin
                if (eb_reg == 4'd0)
                begin
                    fs_next = {24'd0, s1_byte_reg};
                    eb_next = 4'd1;
                end
                else
                begin
                    fs_next    = gather(fs_reg, s1_byte_reg, 2'd1, le_reg);
                    total_next = fs_next[COUNT_W-1:0];
                    if (dir_too_long(dir_off_reg, fs_next[COUNT_W-1:0], file_len))
                    begin
                        fin   = 1'b1;
                        fin_v = VERDICT_DIR_END;
                    end
                    else if (fs_next[COUNT_W-1:0] == '0)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ENTRY;
                        eb_next    = 4'd0;
                        en_next    = '0;
                    end
                end
            end
            PH_ENTRY:
            begin
                if (eb_reg >= 4'd2)
                begin
                    fs_next = gather(fs_reg, s1_byte_reg, ent_k, le_reg);
                end
                if (eb_reg == 4'd3)
                begin
                    ts_next = type_size(fs_next[15:0]);
                end
                if (eb_reg == 4'd7)
                begin
                    vc_next = fs_next;
                end
                if (eb_reg >= ENTRY_LAST)
                begin
                    eb_next = 4'd0;
                    if ((tag_len > INLINE_BYTES) &&
                        (37'(fs_next) + 37'(tag_len) > 37'(file_len)))
                    begin
                        fin     = 1'b1;
                        fin_v   = VERDICT_TAG_END;
                        fin_bad = en_reg;
                    end
                    else
                    begin
                        en_next = en_reg + 1'b1;
                        if (en_next == total_reg)
                        begin
                            fin = 1'b1;
                        end
                    end
                end
                else
                begin
                    eb_next = eb_reg + 1'b1;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (s1_last_reg && !fin && (phase_reg != PH_DONE))
        begin
            fin   = 1'b1;
            fin_v = (phase_next == PH_HEADER) ? VERDICT_TOO_SMALL : VERDICT_DIR_TRUNC;
        end

        if (fin)
        begin
            phase_next = PH_DONE;
        end

        res_le = ((fin_v == VERDICT_NOT_TIFF) || (fin_v == VERDICT_TOO_SMALL)) ? 1'b0 : le_next;

        // drop all file state after the last byte
        if (s1_last_reg)
        begin
            pos_next     = '0;
            le_next      = 1'b0;
            dir_off_next = '0;
            total_next   = '0;
            en_next      = '0;
            eb_next      = 4'd0;
            fs_next      = '0;
            ts_next      = SIZE_ONE;
            vc_next      = '0;
            phase_next   = PH_HEADER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            le_reg      <= 1'b0;
            dir_off_reg <= '0;
            total_reg   <= '0;
            en_reg      <= '0;
            eb_reg      <= 4'd0;
            fs_reg      <= '0;
            ts_reg      <= SIZE_ONE;
            vc_reg      <= '0;
            phase_reg   <= PH_HEADER;
        end
        else if (adv)
        begin
            pos_reg     <= pos_next;
            le_reg      <= le_next;
            dir_off_reg <= dir_off_next;
            total_reg   <= total_next;
            en_reg      <= en_next;
            eb_reg      <= eb_next;
            fs_reg      <= fs_next;
            ts_reg      <= ts_next;
            vc_reg      <= vc_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && (phase_reg == PH_HEADER) && (pos_reg < OFFSET_BITS'(HDR_BYTES)))
        begin
            hdr_reg[pos_reg[2:0]] <= s1_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && fin)
        begin
            out_verdict_reg <= fin_v;
            out_le_reg      <= res_le;
            out_bad_reg     <= fin_bad;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.verdict       = out_verdict_reg;
    assign result.little_endian = out_le_reg;
    assign result.bad_entry     = out_bad_reg;

    `TDBC_ASSERT_NEXT(a_last_clears, clk, rst_n, adv && s1_last_reg,
        (pos_reg == '0) && (phase_reg == PH_HEADER), "file state not cleared after last byte")
    `TDBC_ASSERT_IMPLY(a_entry_byte_range, clk, rst_n, phase_reg == PH_ENTRY,
        eb_reg <= ENTRY_LAST, "entry byte index out of range")
    `TDBC_ASSERT_IMPLY(a_bad_only_tag, clk, rst_n,
        out_valid_reg && (out_verdict_reg != VERDICT_TAG_END),
        out_bad_reg == '0, "bad entry set without tag verdict")
    `TDBC_ASSERT_IMPLY(a_order_cleared, clk, rst_n,
        out_valid_reg && ((out_verdict_reg == VERDICT_NOT_TIFF) ||
        (out_verdict_reg == VERDICT_TOO_SMALL)),
        !out_le_reg, "byte order flagged without valid header")

endmodule

`default_nettype wire

FILE: rtl/tiff_directory_bounds_checker.sv
`default_nettype none

// Streaming bounds checker for classic TIFF structure. File bytes arrive one per request on the
// item channel, in file order, with is_last on the final byte; the file length is set in the
// length register (APB offset 0); the user is to write it only while the block is idle, and the
// block itself does not enforce this. Each byte passes an input register, a combinational parser
// update and a result register: the verdict decided by a byte is registered in the result
// register, where it can be taken. One verdict is given per file, and the bytes after an early
// verdict are consumed silently up to is_last. The block takes one byte per clock cycle while no
// verdict is held; a verdict held by a low result.ready also holds the input register, so bytes
// stall until it is taken. A directory that starts inside the eight-byte header is picked up on
// the eighth byte from the buffered header, which supplies the directory bytes that lie there.

module tiff_directory_bounds_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    tdbc_in_if.sink                          item,
    tdbc_out_if.source                       result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tdbc_pkg::PADDR_W-1:0]     paddr,
    input  logic [tdbc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tdbc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import tdbc_pkg::*;

    logic [FILE_LEN_W-1:0] file_len;

    tdbc_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .file_len  (file_len)
    );

    tdbc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .file_len  (file_len)
    );

endmodule

`default_nettype wire

FILE: dv/tiff_directory_bounds_checker_tb.sv
`timescale 1ns / 1ps

module tiff_directory_bounds_checker_tb;
    import tdbc_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 900;
    localparam logic [PADDR_W-1:0] ADDR_FILE_LEN = {REG_FILE_LEN, 2'b00};
    localparam logic [31:0] SIZE_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic                 little_endian;
        logic [COUNT_W-1:0]   bad_entry;
    } verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tdbc_in_if  in_if ();
    tdbc_out_if out_if ();

    tiff_directory_bounds_checker dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (in_if),
        .result  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    verdict_t   pending_verdicts[$];
    int         error_count;
    int         bytes_sent;
    logic       tx_eager;
    logic       rx_eager;

    logic [31:0] size_reg;
    logic [31:0] position;
    logic [7:0]  header_bytes[8];
    logic        order_le;
    logic [31:0] dir_offset;
    logic [15:0] entry_count;
    logic [15:0] entry_index;
    logic [3:0]  entry_pos;
    logic [31:0] field_acc;
    logic [3:0]  unit_size;
    logic [31:0] value_count;
    phase_t      parse_phase;
    logic        decided;
    logic        decision_made;
    verdict_t    decision;

    logic [7:0]  file_bytes[$];
    logic        build_le;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void restart_file();
        position = '0;
        foreach (header_bytes[i]) header_bytes[i] = '0;
        order_le = 1'b0;
        dir_offset = '0;
        entry_count = '0;
        entry_index = '0;
        entry_pos = '0;
        field_acc = '0;
        unit_size = SIZE_ONE;
        value_count = '0;
        parse_phase = PH_HEADER;
        decided = 1'b0;
    endfunction

    function automatic void decide_verdict(input logic [VERDICT_W-1:0] v,
                                           input logic [COUNT_W-1:0] idx);
        if (decided) return;
        decided = 1'b1;
        parse_phase = PH_DONE;
        decision_made = 1'b1;
        decision.verdict = v;
        decision.bad_entry = idx;
    endfunction

    function automatic void merge_byte(input logic [7:0] b, input logic [1:0] k);
        if (k == 2'd0) field_acc = {24'd0, b};
        else if (order_le) field_acc = field_acc | ({24'd0, b} << (8 * k));
        else field_acc = {field_acc[23:0], b};
    endfunction

    function automatic logic [3:0] bytes_per_value(input logic [15:0] t);
        case (t) inside
            TYPE_SHORT: return SIZE_TWO;
            TYPE_LONG:  return SIZE_FOUR;
            TYPE_RATIONAL, TYPE_SRATIONAL, TYPE_LONG8, TYPE_SLONG8: return SIZE_EIGHT;
            default:    return SIZE_ONE;
        endcase
    endfunction

    function automatic void parse_dir_byte(input logic [7:0] b);
        logic [3:0]  e;
        logic [63:0] span;
        if (parse_phase == PH_COUNT) begin
            merge_byte(b, entry_pos[1:0]);
            if (entry_pos == 4'd0) begin
                entry_pos = 4'd1;
                return;
            end
            entry_count = field_acc[15:0];
            if (64'(dir_offset) + 64'(DIR_FIXED_BYTES) + 64'(entry_count) * 12 > 64'(size_reg))
                decide_verdict(VERDICT_DIR_END, '0);
            else if (entry_count == 16'd0)
                decide_verdict(VERDICT_OK, '0);
            else
            begin
                parse_phase = PH_ENTRY;
                entry_pos = 4'd0;
                entry_index = '0;
            end
        end
        else if (parse_phase == PH_ENTRY) begin
            e = entry_pos;
            if (e >= 4'd8) merge_byte(b, 2'(e - 4'd8));
            else if (e >= 4'd4) merge_byte(b, 2'(e - 4'd4));
            else if (e >= 4'd2) merge_byte(b, 2'(e - 4'd2));
            if (e == 4'd3) unit_size = bytes_per_value(field_acc[15:0]);
            if (e == 4'd7) value_count = field_acc;
            if (e >= ENTRY_LAST) begin
                span = 64'(value_count) * 64'(unit_size);
                entry_pos = 4'd0;
                if (span > 64'd4 && 64'(field_acc) + span > 64'(size_reg))
                    decide_verdict(VERDICT_TAG_END, entry_index);
                else
                begin
                    entry_index = entry_index + 16'd1;
                    if (entry_index == entry_count) decide_verdict(VERDICT_OK, '0);
                end
                return;
            end
            entry_pos = e + 4'd1;
        end
    endfunction

    function automatic void check_header();
        logic        le;
        logic        be;
        logic [31:0] ifd;
        int          p;
        le = header_bytes[0] == CHAR_I && header_bytes[1] == CHAR_I &&
             header_bytes[2] == MAGIC && header_bytes[3] == BYTE_ZERO;
        be = header_bytes[0] == CHAR_M && header_bytes[1] == CHAR_M &&
             header_bytes[2] == BYTE_ZERO && header_bytes[3] == MAGIC;
        if (!le && !be) begin
            decide_verdict(VERDICT_NOT_TIFF, '0);
            return;
        end
        order_le = le;
        if (le) ifd = {header_bytes[7], header_bytes[6], header_bytes[5], header_bytes[4]};
        else ifd = {header_bytes[4], header_bytes[5], header_bytes[6], header_bytes[7]};
        dir_offset = ifd;
        if (ifd == 32'd0)
            decide_verdict(VERDICT_NO_DIR, '0);
        else if (ifd >= size_reg)
            decide_verdict(VERDICT_OFF_END, '0);
        else if (ifd < 32'd8) begin
            parse_phase = PH_COUNT;
            entry_pos = 4'd0;
            for (p = ifd; p < 8 && parse_phase != PH_DONE; p++) parse_dir_byte(header_bytes[p]);
        end
        else
            parse_phase = PH_SKIP;
    endfunction

    function automatic void parse_file_byte(input logic [7:0] b, input logic last);
        logic [31:0] pos;
        pos = position;
        decision_made = 1'b0;
        case (parse_phase)
            PH_HEADER:
            begin
                if (pos < 32'd8) header_bytes[pos[2:0]] = b;
                if (pos == 32'd7) check_header();
            end
            PH_SKIP:
            begin
                if (pos == dir_offset) begin
                    parse_phase = PH_COUNT;
                    entry_pos = 4'd0;
                    parse_dir_byte(b);
                end
            end
            PH_COUNT, PH_ENTRY: parse_dir_byte(b);
            default: ;
        endcase
        if (last && !decided)
            decide_verdict(parse_phase == PH_HEADER ? VERDICT_TOO_SMALL : VERDICT_DIR_TRUNC, '0);
        if (decision_made) begin
            decision.little_endian = (decision.verdict == VERDICT_NOT_TIFF ||
                                      decision.verdict == VERDICT_TOO_SMALL) ? 1'b0 : order_le;
            pending_verdicts.push_back(decision);
        end
        if (pos != SIZE_MAX) position = pos + 32'd1;
        if (last) restart_file();
    endfunction

    always @(posedge clk) begin
        verdict_t want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("verdict %0d arrived with none pending", out_if.verdict);
                error_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (out_if.verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, out_if.verdict);
                    error_count++;
                end
                if (out_if.little_endian !== want.little_endian) begin
                    $error("little_endian: expected %0d, got %0d", want.little_endian,
                           out_if.little_endian);
                    error_count++;
                end
                if (out_if.bad_entry !== want.bad_entry) begin
                    $error("bad_entry: expected %0d, got %0d", want.bad_entry, out_if.bad_entry);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int stall;
        out_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = rx_eager ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge clk); while (!out_if.valid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data_byte <= b;
        in_if.is_last <= last;
        // hold the request until taken
        do @(posedge clk); while (!in_if.ready);
        parse_file_byte(b, last);
        bytes_sent++;
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_file_len(input logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_FILE_LEN;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== v) begin
            $error("file_len: expected %0h, got %0h", v, prdata);
            error_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        size_reg = v;
    endtask

    task automatic send_file(input logic [31:0] fsize);
        settle();
        write_file_len(fsize);
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    function automatic void put16(input logic [15:0] v);
        if (build_le) begin
            file_bytes.push_back(v[7:0]);
            file_bytes.push_back(v[15:8]);
        end
        else
        begin
            file_bytes.push_back(v[15:8]);
            file_bytes.push_back(v[7:0]);
        end
    endfunction

    function automatic void put32(input logic [31:0] v);
        if (build_le) begin
            put16(v[15:0]);
            put16(v[31:16]);
        end
        else
        begin
            put16(v[31:16]);
            put16(v[15:0]);
        end
    endfunction

    function automatic void start_file(input logic le, input logic [31:0] ifd);
        file_bytes.delete();
        build_le = le;
        file_bytes.push_back(le ? CHAR_I : CHAR_M);
        file_bytes.push_back(le ? CHAR_I : CHAR_M);
        put16({8'd0, MAGIC});
        put32(ifd);
    endfunction

    function automatic void put_entry(input logic [15:0] tag, input logic [15:0] kind,
                                      input logic [31:0] count, input logic [31:0] place);
        put16(tag);
        put16(kind);
        put32(count);
        put32(place);
    endfunction

    function automatic void put_noise(input int n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void pad_to(input int n);
        while (file_bytes.size() < n) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic logic [15:0] pick_type();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 18));
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return SIZE_MAX;
            default: return $urandom_range(0, 6);
        endcase
    endfunction

    function automatic logic [31:0] pick_place();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return SIZE_MAX;
            default: return $urandom_range(0, 96);
        endcase
    endfunction

    task automatic test_header_checks();
        file_bytes.delete();
        file_bytes.push_back(CHAR_I);
        send_file(1);
        start_file(1'b1, 32'd8);
        void'(file_bytes.pop_back());
        send_file(64);
        start_file(1'b1, 32'd8);
        file_bytes[2] = 8'd43;
        put_noise(4);
        send_file(16);
        start_file(1'b0, 32'd8);
        file_bytes[0] = CHAR_I;
        send_file(16);
        start_file(1'b0, 32'd8);
        file_bytes[2] = MAGIC;
        file_bytes[3] = BYTE_ZERO;
        send_file(16);
        start_file(1'b1, 32'd0);
        send_file(SIZE_MAX);
        start_file(1'b0, 32'd0);
        put_noise(3);
        send_file(16);
        start_file(1'b1, 32'd100);
        send_file(100);
        start_file(1'b0, 32'd8);
        send_file(32'd0);
    endtask

    task automatic test_directory_in_header();
        int k;
        for (k = 1; k < 8; k++) begin
            start_file(k[0], 32'(k));
            put_noise(40);
            send_file(k[1] ? SIZE_MAX : 32'd64);
        end
    endtask

    task automatic test_directory_span();
        start_file(1'b1, 32'd8);
        put16(16'd3);
        put_noise(4);
        send_file(49);
        start_file(1'b0, 32'd8);
        put16(16'd3);
        repeat (3) put_entry(16'($urandom), 16'd1, 32'd1, 32'd0);
        put32(32'd0);
        send_file(50);
        start_file(1'b1, 32'd12);
        pad_to(12);
        put16(16'd0);
        put32(32'd0);
        send_file(18);
        start_file(1'b0, 32'd8);
        put16(16'hFFFF);
        put_noise(30);
        send_file(SIZE_MAX);
        start_file(1'b1, 32'd40);
        put_noise(12);
        send_file(100);
    endtask

    task automatic test_value_spans();
        logic [15:0] kinds[18] = '{16'd0, 16'd1, 16'd2, TYPE_SHORT, TYPE_LONG, TYPE_RATIONAL,
                                   16'd6, 16'd7, 16'd8, 16'd9, TYPE_SRATIONAL, 16'd11, 16'd12,
                                   16'd13, TYPE_LONG8, TYPE_SLONG8, 16'd18, 16'hFFFF};
        start_file(1'b1, 32'd8);
        put16(16'd18);
        foreach (kinds[i])
            put_entry(16'($urandom), kinds[i], 32'd4 / bytes_per_value(kinds[i]), SIZE_MAX);
        put32(32'd0);
        send_file(230);
        start_file(1'b0, 32'd8);
        put16(16'd3);
        put_entry(16'($urandom), TYPE_RATIONAL, 32'd1, 32'd92);
        put_entry(16'($urandom), TYPE_SHORT, 32'd3, 32'd95);
        put_entry(16'($urandom), TYPE_LONG, 32'd9, 32'd0);
        put_noise(8);
        send_file(100);
        start_file(1'b1, 32'd8);
        put16(16'd1);
        put_entry(16'($urandom), TYPE_SLONG8, SIZE_MAX, SIZE_MAX);
        put32(32'd0);
        send_file(SIZE_MAX);
        start_file(1'b0, 32'd8);
        put16(16'd2);
        put_entry(16'($urandom), TYPE_LONG, 32'd2, 32'd0);
        put_entry(16'($urandom), TYPE_LONG8, 32'd2, 32'd20);
        put32(32'd0);
        send_file(36);
    endtask

    task automatic random_file();
        logic        le;
        logic [31:0] ifd;
        logic [31:0] fsize;
        int          n;
        int          i;
        int          cut;
        int          pick;
        tx_eager = ($urandom_range(0, 3) == 0);
        rx_eager = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            file_bytes.delete();
            put_noise($urandom_range(1, 20));
        end
        else
        begin
            le = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) ifd = $urandom_range(1, 7);
            else ifd = 8 + $urandom_range(0, 12);
            start_file(le, ifd);
            if (ifd >= 32'd8) begin
                pad_to(ifd);
                if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 16'hFFFF);
                else n = $urandom_range(0, 5);
                put16(16'(n));
            end
            else
                n = $urandom_range(0, 5);
            for (i = 0; i < n && i < 6; i++)
                put_entry(16'($urandom), pick_type(), pick_count(), pick_place());
            put32($urandom_range(0, 1) ? 32'd0 : $urandom);
            put_noise($urandom_range(0, 4));
            if (pick == 1) begin
                cut = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end
            else if (pick == 2) begin
                i = $urandom_range(0, 7);
                file_bytes[i] = file_bytes[i] ^ 8'(1 << $urandom_range(0, 7));
            end
        end
        case ($urandom_range(0, 19))
            0:       fsize = '0;
            1:       fsize = SIZE_MAX;
            2, 3:    fsize = $urandom;
            4, 5:    fsize = $urandom_range(0, 64);
            6, 7, 8: fsize = 32'(file_bytes.size()) + $urandom_range(0, 16) - 32'd8;
            default: fsize = 32'(file_bytes.size());
        endcase
        send_file(fsize);
    endtask

    task automatic test_random_files();
        int byte_goal;
        byte_goal = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < byte_goal) random_file();
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    initial begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_if.valid <= 1'b0;
        in_if.data_byte <= '0;
        in_if.is_last <= 1'b0;
        tx_eager = 1'b0;
        rx_eager = 1'b0;
        error_count = 0;
        bytes_sent = 0;
        size_reg = '0;
        restart_file();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_checks();
        test_directory_in_header();
        test_directory_span();
        test_value_spans();
        test_random_files();

        in_if.valid <= 1'b0;
        repeat (200) begin
            if (pending_verdicts.size() == 0) break;
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_verdicts.size() != 0) begin
            $error("%0d verdicts never arrived", pending_verdicts.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tdbc_pkg.sv
rtl/tdbc_in_if.sv
rtl/tdbc_out_if.sv
rtl/tdbc_apb_regs.sv
rtl/tdbc_core.sv
rtl/tiff_directory_bounds_checker.sv
dv/tiff_directory_bounds_checker_tb.sv
